// ===== hdl/utx_pkg.sv =====
// Package for the UTF-16LE to UTF-8 transcoder.
// Holds the word types of both channels, the unit state, the burst record
// and the code constants. No dependencies.
`timescale 1ns / 1ps

package utx_pkg;

  // Input word: one raw byte of the UTF-16LE stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // Output word: one UTF-8 byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } out_word_t;

  // Decoder state kept between input words.
  typedef struct packed {
    logic [7:0] held_low_byte;
    logic       have_low_byte;
    logic [9:0] pending_high_bits;
    logic       have_pending_high;
  } state_t;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  // Up to six UTF-8 bytes produced by one input word, bytes[0] goes first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     at_end;
  } burst_t;

  localparam logic [15:0] Bom        = 16'hFEFF;
  localparam logic [5:0]  HighPrefix = 6'b110110;  // D800..DBFF
  localparam logic [5:0]  LowPrefix  = 6'b110111;  // DC00..DFFF
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [15:0] Lim1       = 16'h0080;
  localparam logic [15:0] Lim2       = 16'h0800;
  localparam logic [7:0]  ContTag    = 8'h80;
  localparam logic [7:0]  Lead2      = 8'hC0;
  localparam logic [7:0]  Lead3      = 8'hE0;
  localparam logic [7:0]  Lead4      = 8'hF0;

  // Three-byte form of a 16-bit unit; index 0 is the lead byte.
  function automatic logic [2:0][7:0] enc_three(input logic [15:0] u);
    logic [2:0][7:0] r;
    r[0] = Lead3 | {4'h0, u[15:12]};
    r[1] = ContTag | {2'b00, u[11:6]};
    r[2] = ContTag | {2'b00, u[5:0]};
    return r;
  endfunction

endpackage

// ===== hdl/utf16le_to_utf8_transcoder_top.sv =====
// UTF-16LE to UTF-8 transcoder, top level.
// Holds the decoder state, the burst register and the output shifter.
// Depends on utx_pkg and utx_encode.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_word_i) takes one raw
//   byte per word, low byte of each 16-bit unit first; in_last marks the
//   final byte and flushes a pending high surrogate, drops an odd byte and
//   clears the state for the next stream. BOM units are dropped.
//   The output channel (out_valid_o / out_stall_i / out_word_o) gives one
//   UTF-8 byte per word; run_last marks the last byte caused by one input
//   word and stream_end the last one caused by the final input word.
// Flow: the first byte of a burst is on the output in the cycle after the
//   input word is taken. Each input word yields 0 to 6 bytes, sent one per
//   cycle from the burst register while the output is not stalled. Words that
//   yield no bytes are taken even while a burst drains. A new burst loads in
//   the cycle the previous one hands over its last byte.
// Reset: clears the decoder state and empties the burst register.
// Stall: a stalled output holds its byte; the input stalls only when a word
//   that yields bytes finds the burst register still occupied.
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  utx_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utx_pkg::out_word_t out_word_o
);
  import utx_pkg::*;

  state_t   state_q, state_d;
  state_t   state_nx;
  burst_t   burst_nx;
  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     end_q, end_d;
  logic                     in_acc;
  logic                     out_acc;
  logic                     buf_free;
  logic                     needs_out;

  utx_encode u_encode (
    .state_i (state_q),
    .word_i  (in_word_i),
    .burst_o (burst_nx),
    .state_o (state_nx)
  );

  // Handshake
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign buf_free    = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !out_stall_i);
  assign needs_out   = (burst_nx.count != '0);
  assign in_stall_o  = needs_out && !buf_free;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Output word
  assign out_word_o.out_byte   = bytes_q[0];
  assign out_word_o.run_last   = (cnt_q == CntW'(1));
  assign out_word_o.stream_end = (cnt_q == CntW'(1)) && end_q;

  // Decoder state
  assign state_d = in_acc ? state_nx : state_q;

  // Burst register: load a new burst or shift out one byte
  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    if (in_acc && needs_out) begin
      bytes_d = burst_nx.bytes;
      cnt_d   = burst_nx.count;
      end_d   = burst_nx.at_end;
    end else if (out_acc) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("burst count out of range");

  a_burst_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && needs_out) |=> out_valid_o)
    else $error("burst not presented after load");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.in_last) |=>
      (!state_q.have_low_byte && !state_q.have_pending_high))
    else $error("state not cleared after last word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && needs_out) |-> (cnt_q == '0 || out_acc))
    else $error("burst overwritten before drained");

endmodule

// ===== hdl/utx_encode.sv =====
// Combinational decode of one input word against the current state.
// Produces the UTF-8 burst for the word and the next state. Uses utx_pkg.
`timescale 1ns / 1ps

module utx_encode (
  input  utx_pkg::state_t   state_i,
  input  utx_pkg::in_word_t word_i,
  output utx_pkg::burst_t   burst_o,
  output utx_pkg::state_t   state_o
);
  import utx_pkg::*;

  logic [15:0]     unit;
  logic            is_low;
  logic            is_high;
  logic [15:0]     pend_unit;
  logic            flush_pend;
  logic [2:0][7:0] pend_bytes;
  logic [2:0][7:0] unit_three;
  logic [20:0]     cp;
  logic [3:0][7:0] s2_bytes;
  logic [2:0]      s2_count;

  assign unit       = {word_i.in_byte, state_i.held_low_byte};
  assign is_low     = (unit[15:10] == LowPrefix);
  assign is_high    = (unit[15:10] == HighPrefix);
  assign pend_unit  = {HighPrefix, state_i.pending_high_bits};
  assign pend_bytes = enc_three(pend_unit);
  assign unit_three = enc_three(unit);
  assign cp = SuppBase + {1'b0, state_i.pending_high_bits, unit[9:0]};

  // Pending high surrogate goes out on its own: broken pair, or end of stream
  assign flush_pend = state_i.have_pending_high &&
                      ((state_i.have_low_byte && !is_low) ||
                       (!state_i.have_low_byte && word_i.in_last));

  // Bytes of the unit itself or of a completed surrogate pair (or of a high surrogate cut off by the end)
  always_comb begin
    s2_bytes = '0;
    s2_count = '0;
    if (state_i.have_low_byte) begin
      priority if (state_i.have_pending_high && is_low) begin
        s2_bytes[0] = Lead4 | {5'h00, cp[20:18]};
        s2_bytes[1] = ContTag | {2'b00, cp[17:12]};
        s2_bytes[2] = ContTag | {2'b00, cp[11:6]};
        s2_bytes[3] = ContTag | {2'b00, cp[5:0]};
        s2_count    = 3'd4;
      end else if (unit == Bom) begin
        s2_count = 3'd0;
      end else if (is_high) begin
        if (word_i.in_last) begin
          s2_bytes[2:0] = unit_three;
          s2_count      = 3'd3;
        end
      end else if (unit < Lim1) begin
        s2_bytes[0] = unit[7:0];
        s2_count    = 3'd1;
      end else if (unit < Lim2) begin
        s2_bytes[0] = Lead2 | {3'b000, unit[10:6]};
        s2_bytes[1] = ContTag | {2'b00, unit[5:0]};
        s2_count    = 3'd2;
      end else begin
        s2_bytes[2:0] = unit_three;
        s2_count      = 3'd3;
      end
    end
  end

  // Assemble the burst: flushed surrogate first, then the unit's bytes
  always_comb begin
    burst_o.at_end = word_i.in_last;
    if (flush_pend) begin
      burst_o.bytes = {s2_bytes[2:0], pend_bytes};
      burst_o.count = s2_count + 3'd3;
    end else begin
      burst_o.bytes = {16'h0000, s2_bytes};
      burst_o.count = s2_count;
    end
  end

  // Next state
  always_comb begin
    state_o = state_i;
    if (!state_i.have_low_byte) begin
      if (word_i.in_last) begin
        state_o = '0;
      end else begin
        state_o.held_low_byte = word_i.in_byte;
        state_o.have_low_byte = 1'b1;
      end
    end else begin
      state_o.held_low_byte     = '0;
      state_o.have_low_byte     = 1'b0;
      state_o.have_pending_high = is_high && !word_i.in_last;
      state_o.pending_high_bits = (is_high && !word_i.in_last) ? unit[9:0] : '0;
    end
  end

endmodule
